FILE: rtl/cpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

	localparam int BYTE_W = 8;
	localparam int SUM16_W = 16;
	localparam int HDR_W = 10;
	localparam int POS_W = 3;
	localparam int FOLD_W = 11;

	localparam logic [POS_W-1:0] POS_MODE = 3'd1;
	localparam logic [POS_W-1:0] POS_HDR_END = 3'd3;
	localparam logic [POS_W-1:0] POS_MIN_EXT_LAST = 3'd5;
	localparam logic [POS_W-1:0] POS_SAT = 3'd6;
	localparam logic [3:0] EXT_NIBBLE = 4'hf;

	typedef struct packed {
		logic                 too_short;
		logic                 extended_packet;
		logic [SUM16_W-1:0]   sum16;
		logic [BYTE_W-1:0]    sum8;
	} result_t;

	function automatic logic [SUM16_W-1:0] add_eac(
		input logic [SUM16_W-1:0] acc,
		input logic [BYTE_W-1:0] b
	);
		logic [SUM16_W:0] s;
		s = {1'b0, acc} + {{(SUM16_W + 1 - BYTE_W){1'b0}}, b};
		return s[SUM16_W-1:0] + {{(SUM16_W - 1){1'b0}}, s[SUM16_W]};
	endfunction

	function automatic logic [BYTE_W-1:0] fold8(input logic [SUM16_W-1:0] v);
		logic [BYTE_W:0] f1;
		logic [BYTE_W:0] f2;
		f1 = {1'b0, v[15:8]} + {1'b0, v[7:0]};
		f2 = {{(BYTE_W){1'b0}}, f1[BYTE_W]} + {1'b0, f1[BYTE_W-1:0]};
		return f2[BYTE_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/cpc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module cpc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output cpc_pkg::result_t       res
);
	import cpc_pkg::*;

	logic [POS_W-1:0]   pos_q;
	logic               ext_q;
	logic [HDR_W-1:0]   hdr_q;
	logic [SUM16_W-1:0] run_q;

	logic               ext_n;
	logic [HDR_W-1:0]   hdr_n;
	logic [SUM16_W-1:0] run_n;
	logic [POS_W-1:0]   pos_n;
	logic               add_en;
	logic               short_n;
	logic [SUM16_W-1:0] s16;
	logic [FOLD_W-1:0]  ext_total;

	always_comb begin
		ext_n = (pos_q == POS_MODE) ? (data_byte[7:4] == EXT_NIBBLE) : ext_q;
		hdr_n = (pos_q >= POS_MODE && pos_q <= POS_HDR_END)
			? hdr_q + {{(HDR_W - BYTE_W){1'b0}}, data_byte} : hdr_q;
		add_en = ext_n ? (pos_q >= POS_SAT) : (pos_q >= POS_MODE);
		run_n = add_en ? add_eac(run_q, data_byte) : run_q;
		pos_n = (pos_q < POS_SAT) ? pos_q + 3'd1 : pos_q;
		short_n = ext_n && (pos_q < POS_MIN_EXT_LAST);
		s16 = (ext_n && !short_n) ? run_n : '0;
		ext_total = {1'b0, hdr_n} + {{(FOLD_W - BYTE_W){1'b0}}, s16[7:0]}
			+ {{(FOLD_W - BYTE_W){1'b0}}, s16[15:8]};
		res.too_short = short_n;
		res.extended_packet = ext_n;
		res.sum16 = s16;
		res.sum8 = ext_n ? fold8({{(SUM16_W - FOLD_W){1'b0}}, ext_total}) : fold8(run_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ext_q <= 1'b0;
			hdr_q <= '0;
			run_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q <= '0;
				ext_q <= 1'b0;
				hdr_q <= '0;
				run_q <= '0;
			end else begin
				pos_q <= pos_n;
				ext_q <= ext_n;
				hdr_q <= hdr_n;
				run_q <= run_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/command_packet_checksum_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata                          tuser                          tlast
// s_*       in   [7:0] data_byte                -                              last_byte
// m_*       out  [7:0] sum8, [23:8] sum16       [0] extended_packet,           -
//                                               [1] too_short
//
// One byte per cycle unless a last byte waits behind a stalled result; a packet's result
// passes the input register, then the result register, before it is offered on m_*.
// The running sum loop (add with end-around carry) is combinational around a single register.
// Reset clears the packet state and both valid flags.
// A stalled result blocks only a further last byte; other bytes keep flowing.

module command_packet_checksum_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] sum8, [23:8] sum16
	output logic [1:0]       m_tuser    // [0] extended_packet, [1] too_short
);
	import cpc_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic        out_valid_q;
	result_t     res;
	result_t     res_q;

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	cpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {res_q.sum16, res_q.sum8};
	assign m_tuser = {res_q.too_short, res_q.extended_packet};

endmodule

`default_nettype wire

FILE: test/tb_command_packet_checksum_top.sv
`timescale 1ns / 1ps

module tb_command_packet_checksum_top;
	import cpc_pkg::*;

	localparam int ITEM_TARGET = 1550;
	localparam int CALM_TAIL = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER = 40;
	localparam int DRAIN_PACKET = 70;
	localparam int HEAVY_LEN = 300;
	localparam logic LAST = 1'b1;
	localparam logic MORE = 1'b0;
	localparam logic PINNED = 1'b1;
	localparam logic FREE = 1'b0;
	localparam result_t NO_SUM = '0;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              pin;
		result_t           sums;
	} stim_row_t;

	// sums: too_short, extended_packet, sum16, sum8
	stim_row_t directed_rows [0:27] = '{
		{8'h00, LAST, PINNED, 1'b0, 1'b0, 16'h0000, 8'h00},
		{8'h55, MORE, FREE, NO_SUM},
		{8'h01, MORE, FREE, NO_SUM},
		{8'h02, LAST, PINNED, 1'b0, 1'b0, 16'h0000, 8'h03},
		{8'h00, MORE, FREE, NO_SUM},
		{8'hf0, LAST, PINNED, 1'b1, 1'b1, 16'h0000, 8'hf0},
		{8'h00, MORE, FREE, NO_SUM},
		{8'hff, MORE, FREE, NO_SUM},
		{8'h01, MORE, FREE, NO_SUM},
		{8'h02, MORE, FREE, NO_SUM},
		{8'h33, LAST, PINNED, 1'b1, 1'b1, 16'h0000, 8'h03},
		{8'h00, MORE, FREE, NO_SUM},
		{8'hf1, MORE, FREE, NO_SUM},
		{8'h00, MORE, FREE, NO_SUM},
		{8'h00, MORE, FREE, NO_SUM},
		{8'h77, MORE, FREE, NO_SUM},
		{8'h88, LAST, PINNED, 1'b0, 1'b1, 16'h0000, 8'hf1},
		{8'h00, MORE, FREE, NO_SUM},
		{8'hff, MORE, FREE, NO_SUM},
		{8'hff, MORE, FREE, NO_SUM},
		{8'hff, MORE, FREE, NO_SUM},
		{8'h00, MORE, FREE, NO_SUM},
		{8'h00, MORE, FREE, NO_SUM},
		{8'hff, MORE, FREE, NO_SUM},
		{8'hff, LAST, FREE, NO_SUM},
		{8'hff, MORE, FREE, NO_SUM},
		{8'hef, MORE, FREE, NO_SUM},
		{8'hff, LAST, FREE, NO_SUM}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0] m_tuser;
	logic row_pinned = 1'b0;
	result_t row_sums = '0;

	logic [POS_W-1:0] pkt_pos = '0;
	logic pkt_ext = 1'b0;
	logic [HDR_W-1:0] hdr_acc = '0;
	logic [SUM16_W-1:0] chk_acc = '0;
	result_t pending_sums [$];

	int faults = 0;
	int cycles = 0;
	int items_sent = 0;
	int bytes_seen = 0;
	int results_seen = 0;
	int ext_seen = 0;
	int short_seen = 0;
	int gap_odds = 6;
	bit calm = 1'b0;
	bit held = 1'b0;
	bit rx_quiet = 1'b0;

	command_packet_checksum_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [7:0] b);
		int s;
		s = int'(acc) + int'(b);
		if (s > 16'hffff)
			s = s - 16'hffff;
		return s[15:0];
	endfunction

	function automatic logic [7:0] fold_to_byte(input int v);
		v = (v >> 8) + (v & 255);
		v = (v >> 8) + (v & 255);
		return v[7:0];
	endfunction

	task automatic track_packet_byte(input logic [7:0] b, input logic l, output logic done,
			output result_t r);
		logic [POS_W-1:0] pos;
		logic [SUM16_W-1:0] s16;
		pos = pkt_pos;
		done = l;
		r = NO_SUM;
		if (pos == POS_MODE)
			pkt_ext = (b[7:4] == EXT_NIBBLE);
		if (pos >= POS_MODE && pos <= POS_HDR_END)
			hdr_acc = hdr_acc + {{(HDR_W - BYTE_W){1'b0}}, b};
		if (pkt_ext) begin
			if (pos >= POS_SAT)
				chk_acc = ones_add(chk_acc, b);
		end else if (pos >= POS_MODE) begin
			chk_acc = ones_add(chk_acc, b);
		end
		if (pkt_pos < POS_SAT)
			pkt_pos = pkt_pos + 3'd1;
		if (l) begin
			r.extended_packet = pkt_ext;
			if (pkt_ext) begin
				r.too_short = (pos < POS_MIN_EXT_LAST);
				s16 = r.too_short ? '0 : chk_acc;
				r.sum16 = s16;
				r.sum8 = fold_to_byte(int'(hdr_acc) + int'(s16[7:0]) + int'(s16[15:8]));
			end else begin
				r.sum8 = fold_to_byte(int'(chk_acc));
			end
			pkt_pos = '0;
			pkt_ext = 1'b0;
			hdr_acc = '0;
			chk_acc = '0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic l, input logic pin, input result_t r);
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		row_pinned <= pin;
		row_sums <= r;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		calm = (items_sent >= ITEM_TARGET - CALM_TAIL);
	endtask

	task automatic send_packet(input int len, input bit ext, input bit heavy);
		logic [7:0] b;
		for (int k = 0; k < len; k++) begin
			b = 8'($urandom);
			if (heavy)
				b[7:5] = 3'b111;
			else if ($urandom_range(0, 7) == 0)
				b = $urandom_range(0, 1) ? 8'hff : 8'h00;
			if (k == 1) begin
				if (ext)
					b[7:4] = EXT_NIBBLE;
				else if (heavy)
					b[4] = 1'b0;
			end
			send_byte(b, k == len - 1, FREE, NO_SUM);
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin : accept_side
		logic done;
		result_t r;
		if (arst_n && s_tvalid && s_tready) begin
			bytes_seen++;
			track_packet_byte(s_tdata, s_tlast, done, r);
			if (done)
				pending_sums.push_back(row_pinned ? row_sums : r);
		end
	end

	always @(posedge clk) begin : result_side
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.sum8 = m_tdata[7:0];
			got.sum16 = m_tdata[23:8];
			got.extended_packet = m_tuser[0];
			got.too_short = m_tuser[1];
			results_seen++;
			ext_seen += got.extended_packet;
			short_seen += got.too_short;
			if (pending_sums.size() == 0) begin
				$error("result with none pending: sum8 %0h sum16 %0h", got.sum8, got.sum16);
				faults++;
			end else begin
				want = pending_sums.pop_front();
				if (got.sum8 !== want.sum8) begin
					$error("sum8: expected %0h, got %0h", want.sum8, got.sum8);
					faults++;
				end
				if (got.sum16 !== want.sum16) begin
					$error("sum16: expected %0h, got %0h", want.sum16, got.sum16);
					faults++;
				end
				if (got.extended_packet !== want.extended_packet) begin
					$error("extended_packet: expected %0b, got %0b", want.extended_packet,
						got.extended_packet);
					faults++;
				end
				if (got.too_short !== want.too_short) begin
					$error("too_short: expected %0b, got %0b", want.too_short, got.too_short);
					faults++;
				end
			end
		end
	end

	initial begin
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 149) == 0)
				rx_quiet = !rx_quiet;
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].pin,
				directed_rows[i].sums);
		for (int pkt = 0; items_sent < ITEM_TARGET; pkt++) begin
			gap_odds = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 3 : 9);
			if (pkt == DRAIN_PACKET) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_sums.size() != 0)
					@(posedge clk);
			end
			if (pkt == 3 || pkt == 100)
				send_packet(HEAVY_LEN, pkt == 100, 1'b1);
			else if ($urandom_range(0, 9) == 0)
				send_packet($urandom_range(15, 40), 1'($urandom_range(0, 1)), 1'b0);
			else
				send_packet($urandom_range(1, 12), 1'($urandom_range(0, 1)), 1'b0);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("checked %0d packet checksums over %0d bytes: %0d extended, %0d short",
			results_seen, bytes_seen, ext_seen, short_seen);
		$display("output held off for %0d cycles once, input drained once mid-run", HOLD_CYCLES);
		if (faults == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cpc_pkg.sv
rtl/cpc_core.sv
rtl/command_packet_checksum_top.sv
test/tb_command_packet_checksum_top.sv
